// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked property, disabled while reset is asserted (active-low reset).
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);
// Clocked property that is checked during reset as well.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: src/rir_pkg.sv
// ----------------------------------------------------------------------------
// rir_pkg
// Types, codes and helpers for the rectangle intersection/remainder block.
// ----------------------------------------------------------------------------
package rir_pkg;

    // Coordinate width; starts are one bit narrower than counts and ends.
    localparam int COORD_BITS = 32;
    localparam int START_BITS = COORD_BITS - 1;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [START_BITS-1:0] t_start;

    // Largest legal count, 2^(COORD_BITS-1)
    localparam t_coord COUNT_LIMIT = {1'b1, {START_BITS{1'b0}}};

    // Result kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_INTER    = 2'd0;
    localparam t_kind KIND_REST     = 2'd1;
    localparam t_kind KIND_DISJOINT = 2'd2;

    // Piece slots, in emission order
    localparam int PC_INTER    = 0;
    localparam int PC_ROW_HEAD = 1;
    localparam int PC_ROW_TAIL = 2;
    localparam int PC_COL_HEAD = 3;
    localparam int PC_COL_TAIL = 4;
    localparam int PIECE_COUNT = 5;

    typedef logic [PIECE_COUNT-1:0] t_piece_mask;

    // Job queue between front and back (power-of-two depth)
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Input transaction
    typedef struct packed {
        t_start query_row_start;
        t_coord query_row_count;
        t_start query_col_start;
        t_coord query_col_count;
        t_start cached_row_start;
        t_coord cached_row_count;
        t_start cached_col_start;
        t_coord cached_col_count;
    } t_req;

    // Output transaction
    typedef struct packed {
        t_kind  piece_kind;
        t_coord row_start;
        t_coord row_count;
        t_coord col_start;
        t_coord col_count;
        logic   last;
    } t_res;

    // Classification flags of one job
    typedef struct packed {
        logic overlap;
        logic row_head;
        logic row_tail;
        logic col_head;
        logic col_tail;
    } t_job_flags;

    // Classified job: query span, intersection span, flags
    typedef struct packed {
        t_job_flags flags;
        t_coord     q_rs;
        t_coord     q_re;
        t_coord     q_cs;
        t_coord     q_ce;
        t_coord     i_rs;
        t_coord     i_re;
        t_coord     i_cs;
        t_coord     i_ce;
    } t_job;

    // Saturate a count to the legal range
    function automatic t_coord cap_count(input t_coord c);
        return (c > COUNT_LIMIT) ? COUNT_LIMIT : c;
    endfunction

    function automatic t_coord max_coord(input t_coord a, input t_coord b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_coord min_coord(input t_coord a, input t_coord b);
        return (a < b) ? a : b;
    endfunction

endpackage

// File: src/rir_front.sv
// ----------------------------------------------------------------------------
// rir_front
// Two-stage front end: saturates inputs, then forms spans and classifies.
// ----------------------------------------------------------------------------
module rir_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rir_pkg::t_req i_req,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output rir_pkg::t_job o_job
);

    typedef struct packed {
        rir_pkg::t_coord q_rs;
        rir_pkg::t_coord q_rc;
        rir_pkg::t_coord q_cs;
        rir_pkg::t_coord q_cc;
        rir_pkg::t_coord c_rs;
        rir_pkg::t_coord c_rc;
        rir_pkg::t_coord c_cs;
        rir_pkg::t_coord c_cc;
    } t_stage_a;

    logic            r_a_valid, n_a_valid;
    logic            r_b_valid, n_b_valid;
    t_stage_a        r_a, n_a;
    rir_pkg::t_job   r_b, n_b;
    logic            w_a_free, w_b_free, w_a_load, w_b_load;
    rir_pkg::t_coord w_q_re, w_q_ce, w_c_re, w_c_ce;

    // Pipeline handshake
    assign w_b_free  = !r_b_valid || i_job_ready;
    assign w_a_free  = !r_a_valid || w_b_free;
    assign w_a_load  = i_valid && w_a_free;
    assign w_b_load  = r_a_valid && w_b_free;
    assign n_a_valid = w_a_free ? i_valid : 1'b1;
    assign n_b_valid = w_b_free ? r_a_valid : 1'b1;
    assign o_ready   = w_a_free;

    // Stage A: widen starts, saturate counts
    always_comb begin
        n_a.q_rs = {1'b0, i_req.query_row_start};
        n_a.q_rc = rir_pkg::cap_count(i_req.query_row_count);
        n_a.q_cs = {1'b0, i_req.query_col_start};
        n_a.q_cc = rir_pkg::cap_count(i_req.query_col_count);
        n_a.c_rs = {1'b0, i_req.cached_row_start};
        n_a.c_rc = rir_pkg::cap_count(i_req.cached_row_count);
        n_a.c_cs = {1'b0, i_req.cached_col_start};
        n_a.c_cc = rir_pkg::cap_count(i_req.cached_col_count);
    end

    // Stage B: ends (never overflow COORD_BITS) and intersection bounds
    assign w_q_re = r_a.q_rs + r_a.q_rc;
    assign w_q_ce = r_a.q_cs + r_a.q_cc;
    assign w_c_re = r_a.c_rs + r_a.c_rc;
    assign w_c_ce = r_a.c_cs + r_a.c_cc;

    always_comb begin
        n_b       = r_b;
        n_b.flags = '0;
        n_b.q_rs  = r_a.q_rs;
        n_b.q_re  = w_q_re;
        n_b.q_cs  = r_a.q_cs;
        n_b.q_ce  = w_q_ce;
        n_b.i_rs  = rir_pkg::max_coord(r_a.q_rs, r_a.c_rs);
        n_b.i_re  = rir_pkg::min_coord(w_q_re, w_c_re);
        n_b.i_cs  = rir_pkg::max_coord(r_a.q_cs, r_a.c_cs);
        n_b.i_ce  = rir_pkg::min_coord(w_q_ce, w_c_ce);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
        end
        if (w_a_load) begin
            r_a <= n_a;
        end
        if (w_b_load) begin
            r_b <= n_b;
        end
    end

    // Classification off the stage B registers
    always_comb begin
        o_job                = r_b;
        o_job.flags.overlap  = (r_b.i_rs < r_b.i_re) && (r_b.i_cs < r_b.i_ce);
        o_job.flags.row_head = r_b.q_rs < r_b.i_rs;
        o_job.flags.row_tail = r_b.i_re < r_b.q_re;
        o_job.flags.col_head = r_b.q_cs < r_b.i_cs;
        o_job.flags.col_tail = r_b.i_ce < r_b.q_ce;
    end

    assign o_job_valid = r_b_valid;

endmodule

// File: src/rir_queue.sv
// ----------------------------------------------------------------------------
// rir_queue
// Small register FIFO of classified jobs between front and back.
// ----------------------------------------------------------------------------
module rir_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  rir_pkg::t_job i_push_job,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output rir_pkg::t_job o_pop_job
);

    rir_pkg::t_job                r_mem [rir_pkg::QUEUE_DEPTH];
    logic [rir_pkg::QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [rir_pkg::QUEUE_AW:0]   r_count;
    logic                         w_push, w_pop;

    localparam logic [rir_pkg::QUEUE_AW:0] FULL_COUNT = rir_pkg::QUEUE_AW'(0) |
        (rir_pkg::QUEUE_AW+1)'(rir_pkg::QUEUE_DEPTH);

    assign o_push_ready = r_count != FULL_COUNT;
    assign o_pop_valid  = r_count != '0;
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop_job    = r_mem[r_rd_ptr];

    // Pointers wrap naturally at a power-of-two depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

// File: src/rir_back.sv
// ----------------------------------------------------------------------------
// rir_back
// Back end: walks the pieces of the head job, one result per cycle while the output is accepted.
// ----------------------------------------------------------------------------
module rir_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_pop,
    input  rir_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output rir_pkg::t_res o_res
);

    logic                 r_out_valid;
    rir_pkg::t_res        r_res, n_res;
    rir_pkg::t_piece_mask r_sent, n_sent;
    rir_pkg::t_piece_mask w_enable, w_pending, w_sel, w_after;
    rir_pkg::t_coord      w_rs, w_re, w_cs, w_ce;
    logic                 w_load, w_last;

    // Pieces present for this job; slot 0 is the intersection or the disjoint
    always_comb begin
        w_enable                       = '0;
        w_enable[rir_pkg::PC_INTER]    = 1'b1;
        w_enable[rir_pkg::PC_ROW_HEAD] = i_job.flags.overlap && i_job.flags.row_head;
        w_enable[rir_pkg::PC_ROW_TAIL] = i_job.flags.overlap && i_job.flags.row_tail;
        w_enable[rir_pkg::PC_COL_HEAD] = i_job.flags.overlap && i_job.flags.col_head;
        w_enable[rir_pkg::PC_COL_TAIL] = i_job.flags.overlap && i_job.flags.col_tail;
    end

    assign w_pending = w_enable & ~r_sent;
    assign w_sel     = w_pending & (~w_pending + 1'b1);
    assign w_after   = w_pending & ~w_sel;
    assign w_last    = w_after == '0;
    assign w_load    = i_job_valid && (!r_out_valid || i_ready);
    assign o_job_pop = w_load && w_last;

    // Span of the selected piece, as start/end pairs
    always_comb begin
        w_rs = i_job.i_rs;
        w_re = i_job.i_re;
        w_cs = i_job.i_cs;
        w_ce = i_job.i_ce;
        priority if (w_sel[rir_pkg::PC_INTER] && !i_job.flags.overlap) begin
            w_rs = i_job.q_rs;
            w_re = i_job.q_re;
            w_cs = i_job.q_cs;
            w_ce = i_job.q_ce;
        end else if (w_sel[rir_pkg::PC_INTER]) begin
            w_rs = i_job.i_rs;
        end else if (w_sel[rir_pkg::PC_ROW_HEAD]) begin
            w_rs = i_job.q_rs;
            w_re = i_job.i_rs;
            w_cs = i_job.q_cs;
            w_ce = i_job.q_ce;
        end else if (w_sel[rir_pkg::PC_ROW_TAIL]) begin
            w_rs = i_job.i_re;
            w_re = i_job.q_re;
            w_cs = i_job.q_cs;
            w_ce = i_job.q_ce;
        end else if (w_sel[rir_pkg::PC_COL_HEAD]) begin
            w_cs = i_job.q_cs;
            w_ce = i_job.i_cs;
        end else begin
            w_cs = i_job.i_ce;
            w_ce = i_job.q_ce;
        end
    end

    // Next result; disjoint counts come back exactly as end minus start
    always_comb begin
        n_res.piece_kind = rir_pkg::KIND_REST;
        if (w_sel[rir_pkg::PC_INTER]) begin
            n_res.piece_kind = i_job.flags.overlap ? rir_pkg::KIND_INTER
                                                   : rir_pkg::KIND_DISJOINT;
        end
        n_res.row_start = w_rs;
        n_res.row_count = w_re - w_rs;
        n_res.col_start = w_cs;
        n_res.col_count = w_ce - w_cs;
        n_res.last      = w_last;
        n_sent          = w_last ? '0 : (r_sent | w_sel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sent      <= '0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_sent      <= n_sent;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_load) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

endmodule

// File: src/rect_intersect_and_remainder.sv
// ----------------------------------------------------------------------------
// rect_intersect_and_remainder
// Intersects a query rectangle with a cached one and splits off the rest.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready, i_req) takes one query/cached rectangle
//   pair per transaction. Output channel (o_valid/i_ready, o_res) returns
//   one rectangle per transaction: a single disjoint result, or the
//   intersection followed by up to four remaining pieces (row head, row
//   tail, column head, column tail); the final one carries last.
//   Path: an item passes the front stage A and B registers, the job
//   queue and the back end output register. Throughput: one result per
//   cycle from the back end while i_ready is high; the front end accepts
//   a new item every cycle while its two-entry job queue has room.
//   Reset (synchronous, active low) empties the pipeline and the queue;
//   there is no other state. When the receiver holds i_ready low, the
//   output register holds, the queue fills, and o_ready drops once the
//   front pipeline is full as well.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rect_intersect_and_remainder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rir_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output rir_pkg::t_res o_res
);

    logic          w_fj_valid, w_fj_ready;
    rir_pkg::t_job w_fj;
    logic          w_q_valid, w_q_pop;
    rir_pkg::t_job w_q_job;

    // Front end: saturate and classify
    rir_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .o_job_valid(w_fj_valid),
        .i_job_ready(w_fj_ready),
        .o_job      (w_fj)
    );

    // Job queue
    rir_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(w_fj_valid),
        .o_push_ready(w_fj_ready),
        .i_push_job  (w_fj),
        .o_pop_valid (w_q_valid),
        .i_pop_ready (w_q_pop),
        .o_pop_job   (w_q_job)
    );

    // Back end: emit pieces
    rir_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(w_q_valid),
        .o_job_pop  (w_q_pop),
        .i_job      (w_q_job),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (o_res)
    );

    // Checks
    `ASSERT_CLK(a_disjoint_last, i_clk, i_rst_n,
        o_valid && (o_res.piece_kind == rir_pkg::KIND_DISJOINT) |-> o_res.last,
        "disjoint result without last")
    `ASSERT_CLK(a_rest_nonempty, i_clk, i_rst_n,
        o_valid && (o_res.piece_kind == rir_pkg::KIND_REST) |->
            (o_res.row_count != '0) && (o_res.col_count != '0),
        "empty remaining piece emitted")
    `ASSERT_CLK(a_head_job_holds, i_clk, i_rst_n,
        w_q_valid && !w_q_pop |=> w_q_valid && $stable(w_q_job),
        "queue head changed before the back end finished it")

endmodule
